// File: hdl/ilgpc_pkg.sv
// Shared types, constants and the duty scaling function of the IR lamp controller.
package ilgpc_pkg;

	localparam int unsigned STABLE_TICKS = 5;
	localparam int unsigned CNT_W        = $clog2(STABLE_TICKS + 1);
	localparam int unsigned GAIN_W       = 16;
	localparam int unsigned DUTY_W       = 7;
	localparam int unsigned PERMILLE_W   = 10;
	localparam int unsigned QUEUE_DEPTH  = 2;
	localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);

	localparam int unsigned DUTY_MAX     = 99;
	localparam int unsigned DUTY_FULL    = 100;
	localparam int unsigned DUTY_MIN     = 1;
	localparam int unsigned OFF_STEP     = 20;
	localparam int unsigned OFF_FLOOR    = 100;
	localparam int unsigned ON_RESET     = 1582;

	// gain*99/1582 exceeds 99 from this gain upwards
	localparam int unsigned SAT_GAIN     = 1598;
	localparam int unsigned SAT_W        = 11;
	// 99 * ceil(2^29 / 1582): exact quotient for every product up to 99*SAT_GAIN
	localparam int unsigned RECIP        = 33596937;
	localparam int unsigned RECIP_W      = 26;
	localparam int unsigned RECIP_SHIFT  = 29;
	localparam int unsigned PROD_W       = SAT_W + RECIP_W;

	typedef enum logic [1:0] {
		MODE_CLOSE = 2'd0,
		MODE_OPEN  = 2'd1,
		MODE_AUTO  = 2'd2,
		MODE_SPARE = 2'd3
	} light_mode_t;

	typedef enum logic [1:0] {
		DRV_CLOSED  = 2'd0,
		DRV_RUNNING = 2'd1,
		DRV_UNKNOWN = 2'd3
	} drv_mode_t;

	typedef enum logic [1:0] {
		REG_LIGHT_MODE = 2'd0,
		REG_ON_THR     = 2'd1,
		REG_OFF_THR    = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic [GAIN_W-1:0] gain;
		logic              qualified;
		logic [DUTY_W-1:0] gain_duty;
		logic [DUTY_W-1:0] thr_duty;
	} item_t;

	typedef struct packed {
		logic                  running;
		logic [PERMILLE_W-1:0] duty_permille;
		logic                  written;
		logic                  start;
		logic                  stop;
		logic                  qualified;
	} result_t;

	function automatic logic [DUTY_W-1:0] scale_duty(input logic [GAIN_W-1:0] g);
		logic [SAT_W-1:0]  gc;
		logic [PROD_W-1:0] prod;
		logic [PROD_W-RECIP_SHIFT-1:0] q;
		gc   = (g >= GAIN_W'(SAT_GAIN)) ? SAT_W'(SAT_GAIN) : g[SAT_W-1:0];
		prod = PROD_W'(gc) * PROD_W'(RECIP);
		q    = prod[PROD_W-1:RECIP_SHIFT];
		return (q > (PROD_W-RECIP_SHIFT)'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX) : q[DUTY_W-1:0];
	endfunction

endpackage

// File: hdl/ilgpc_front.sv
// Front end: gain stability qualification and duty scaling of each tick.
module ilgpc_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic [ilgpc_pkg::GAIN_W-1:0]        gain,
	input  ilgpc_pkg::light_mode_t              light_mode,
	input  logic [ilgpc_pkg::GAIN_W-1:0]        on_thr,
	input  logic                                queue_ready,
	output logic                                push,
	output ilgpc_pkg::item_t                    item
);

	logic [ilgpc_pkg::CNT_W-1:0]  count_q;
	logic [ilgpc_pkg::GAIN_W-1:0] ref_gain_q;
	logic [ilgpc_pkg::CNT_W-1:0]  count_n;
	logic [ilgpc_pkg::GAIN_W-1:0] ref_gain_n;

	assign push = in_valid && queue_ready;

	always_comb begin
		count_n    = count_q;
		ref_gain_n = ref_gain_q;
		// close mode freezes the counter
		if (light_mode != ilgpc_pkg::MODE_CLOSE) begin
			if (count_q == '0 || count_q == ilgpc_pkg::CNT_W'(ilgpc_pkg::STABLE_TICKS)) begin
				count_n    = ilgpc_pkg::CNT_W'(1);
				ref_gain_n = gain;
			end else if (ref_gain_q == gain) begin
				count_n = count_q + ilgpc_pkg::CNT_W'(1);
			end else begin
				count_n = '0;
			end
		end
	end

	always_comb begin
		item.gain      = gain;
		item.qualified = (light_mode != ilgpc_pkg::MODE_CLOSE) &&
			(count_n == ilgpc_pkg::CNT_W'(ilgpc_pkg::STABLE_TICKS));
		item.gain_duty = ilgpc_pkg::scale_duty(gain);
		item.thr_duty  = ilgpc_pkg::scale_duty(on_thr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			ref_gain_q <= '0;
		end else if (push) begin
			count_q    <= count_n;
			ref_gain_q <= ref_gain_n;
		end
	end

endmodule

// File: hdl/ilgpc_queue.sv
// Two-entry queue between the front end and the lamp control back end.
module ilgpc_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ilgpc_pkg::item_t push_item,
	output logic             ready,
	input  logic             pop,
	output logic             avail,
	output ilgpc_pkg::item_t head
);

	localparam int unsigned CNT_W = ilgpc_pkg::QPTR_W + 1;

	ilgpc_pkg::item_t             mem_q [ilgpc_pkg::QUEUE_DEPTH];
	logic [ilgpc_pkg::QPTR_W-1:0] wr_q;
	logic [ilgpc_pkg::QPTR_W-1:0] rd_q;
	logic [CNT_W-1:0]             cnt_q;

	assign ready = cnt_q != CNT_W'(ilgpc_pkg::QUEUE_DEPTH);
	assign avail = cnt_q != '0;
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + ilgpc_pkg::QPTR_W'(1);
			if (pop) rd_q <= rd_q + ilgpc_pkg::QPTR_W'(1);
			if (push && !pop) cnt_q <= cnt_q + CNT_W'(1);
			else if (pop && !push) cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(ilgpc_pkg::QUEUE_DEPTH))
		else $error("queue count beyond depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> avail)
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> ready)
		else $error("push into full queue");

endmodule

// File: hdl/ilgpc_back.sv
// Back end: lamp on/off and duty decisions, PWM driver state and result register.
module ilgpc_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          avail,
	input  ilgpc_pkg::item_t              head,
	output logic                          pop,
	input  ilgpc_pkg::light_mode_t        light_mode,
	input  logic [ilgpc_pkg::GAIN_W-1:0]  on_thr,
	input  logic [ilgpc_pkg::GAIN_W-1:0]  off_thr,
	output logic                          out_valid,
	input  logic                          out_ready,
	output ilgpc_pkg::result_t            result
);

	logic [ilgpc_pkg::DUTY_W-1:0] auto_duty_q, auto_duty_n;
	logic                         auto_started_q, auto_started_n;
	logic                         just_opened_q, just_opened_n;
	logic [ilgpc_pkg::GAIN_W-1:0] learned_q, learned_n;
	ilgpc_pkg::drv_mode_t         drv_mode_q, drv_mode_n;
	logic [ilgpc_pkg::DUTY_W-1:0] drv_duty_q, drv_duty_n;
	logic                         out_valid_q;
	ilgpc_pkg::result_t           result_q, result_n;

	logic                         close_req;
	logic                         open_req;
	logic [ilgpc_pkg::DUTY_W-1:0] open_duty;
	logic                         ev_written, ev_start, ev_stop;
	logic                         running;

	assign pop       = avail && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign result    = result_q;

	always_comb begin
		auto_duty_n    = auto_duty_q;
		auto_started_n = auto_started_q;
		just_opened_n  = just_opened_q;
		learned_n      = learned_q;
		close_req      = 1'b0;
		open_req       = 1'b0;
		open_duty      = auto_duty_q;

		if (light_mode == ilgpc_pkg::MODE_CLOSE) begin
			close_req = 1'b1;
		end else if (head.qualified) begin
			case (light_mode)
				ilgpc_pkg::MODE_OPEN: begin
					if (head.gain > on_thr) begin
						auto_duty_n   = ilgpc_pkg::DUTY_W'(ilgpc_pkg::DUTY_MAX);
						just_opened_n = 1'b1;
						learned_n     = on_thr;
						open_req      = 1'b1;
						open_duty     = ilgpc_pkg::DUTY_W'(ilgpc_pkg::DUTY_MAX);
					end else if (head.gain < learned_q) begin
						if (just_opened_q) begin
							// lower the learned level once by a margin
							learned_n = (head.gain > ilgpc_pkg::GAIN_W'(ilgpc_pkg::OFF_FLOOR)) ?
								head.gain - ilgpc_pkg::GAIN_W'(ilgpc_pkg::OFF_STEP) : head.gain;
						end else begin
							close_req = 1'b1;
							learned_n = '0;
						end
						just_opened_n = 1'b0;
					end
				end
				ilgpc_pkg::MODE_AUTO: begin
					if (head.gain > on_thr) begin
						if (!auto_started_q) begin
							auto_duty_n    = head.thr_duty;
							auto_started_n = 1'b1;
						end else begin
							auto_duty_n = head.gain_duty;
						end
						open_req  = 1'b1;
						open_duty = auto_duty_n;
					end else if (head.gain < off_thr) begin
						if (auto_duty_q < ilgpc_pkg::DUTY_W'(2)) begin
							close_req      = 1'b1;
							auto_started_n = 1'b0;
						end else begin
							auto_duty_n = auto_duty_q >> 1;
							open_req    = 1'b1;
							open_duty   = auto_duty_n;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// PWM driver: start, stop and clamped duty writes
	always_comb begin
		drv_mode_n = drv_mode_q;
		drv_duty_n = drv_duty_q;
		ev_written = 1'b0;
		ev_start   = 1'b0;
		ev_stop    = 1'b0;
		if (close_req && drv_mode_q != ilgpc_pkg::DRV_CLOSED) begin
			drv_mode_n = ilgpc_pkg::DRV_CLOSED;
			drv_duty_n = '0;
			ev_stop    = 1'b1;
		end
		if (open_req) begin
			if (drv_duty_q != open_duty) begin
				if (open_duty >= ilgpc_pkg::DUTY_W'(ilgpc_pkg::DUTY_FULL))
					drv_duty_n = ilgpc_pkg::DUTY_W'(ilgpc_pkg::DUTY_MAX);
				else if (open_duty <= ilgpc_pkg::DUTY_W'(ilgpc_pkg::DUTY_MIN))
					drv_duty_n = ilgpc_pkg::DUTY_W'(ilgpc_pkg::DUTY_MIN);
				else
					drv_duty_n = open_duty;
				ev_written = 1'b1;
			end
			if (drv_mode_q != ilgpc_pkg::DRV_RUNNING) begin
				drv_mode_n = ilgpc_pkg::DRV_RUNNING;
				ev_start   = 1'b1;
			end
		end
	end

	always_comb begin
		running                = drv_mode_n == ilgpc_pkg::DRV_RUNNING;
		result_n.running       = running;
		// duty * 10 as (duty << 3) + (duty << 1)
		result_n.duty_permille = running ?
			({3'b000, drv_duty_n} << 3) + ({3'b000, drv_duty_n} << 1) : '0;
		result_n.written       = ev_written;
		result_n.start         = ev_start;
		result_n.stop          = ev_stop;
		result_n.qualified     = head.qualified;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_duty_q    <= '0;
			auto_started_q <= 1'b0;
			just_opened_q  <= 1'b0;
			learned_q      <= '0;
			drv_mode_q     <= ilgpc_pkg::DRV_UNKNOWN;
			drv_duty_q     <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (pop) begin
				auto_duty_q    <= auto_duty_n;
				auto_started_q <= auto_started_n;
				just_opened_q  <= just_opened_n;
				learned_q      <= learned_n;
				drv_mode_q     <= drv_mode_n;
				drv_duty_q     <= drv_duty_n;
				out_valid_q    <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) result_q <= result_n;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(result_q.start && result_q.stop))
		else $error("start and stop in one result");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (result_q.start || result_q.written) |-> result_q.running)
		else $error("start or duty write without running lamp");
	assert property (@(posedge clk) disable iff (!arst_n)
		drv_duty_q <= ilgpc_pkg::DUTY_W'(ilgpc_pkg::DUTY_MAX))
		else $error("driver duty above maximum");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.stop |-> result_q.duty_permille == '0)
		else $error("stop with non-zero duty");

endmodule

// File: hdl/ir_light_gain_pwm_controller_unit.sv
// Top level of the gain driven IR lamp PWM controller.
// Usage:
//   Slave stream (s_tvalid/s_tready/s_tdata) takes one periodic tick per request,
//   carrying the 16-bit sensor gain. Master stream (m_tvalid/m_tready/m_tdata)
//   returns exactly one result per tick: lamp state, duty in per mille and the
//   start, stop, duty-write and qualification flags.
//   Configuration goes through cfg_we/cfg_index/cfg_data: index 0 light mode,
//   1 on gain threshold, 2 off gain threshold. Write only while no tick is
//   in flight.
// Data flow and throughput:
//   A tick enters the front end (stability count and gain scaling) and is
//   written into a two-entry queue at the edge it is accepted; the back end
//   pops it once its result register is free and registers its result there,
//   which then shows on the master side. One tick per cycle is sustained
//   while m_tready stays high.
// Reset and stalls:
//   arst_n clears the registers to lamp mode close, on threshold 1582, off
//   threshold 0, and the driver to an unknown state. While m_tready is low the
//   result holds; the queue fills up to its two entries, then s_tready drops.
module ir_light_gain_pwm_controller_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [15:0] gain_sample
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] lamp_running, [10:1] duty_permille, [11] duty_written,
	// [12] start_pulse, [13] stop_pulse, [14] gain_qualified, [15] zero
	output logic [15:0] m_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	ilgpc_pkg::light_mode_t       light_mode_q;
	logic [ilgpc_pkg::GAIN_W-1:0] on_thr_q;
	logic [ilgpc_pkg::GAIN_W-1:0] off_thr_q;

	logic               push;
	logic               q_ready;
	logic               pop;
	logic               avail;
	ilgpc_pkg::item_t   push_item;
	ilgpc_pkg::item_t   head;
	ilgpc_pkg::result_t result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_mode_q <= ilgpc_pkg::MODE_CLOSE;
			on_thr_q     <= ilgpc_pkg::GAIN_W'(ilgpc_pkg::ON_RESET);
			off_thr_q    <= '0;
		end else if (cfg_we) begin
			case (ilgpc_pkg::reg_index_t'(cfg_index))
				ilgpc_pkg::REG_LIGHT_MODE: light_mode_q <= ilgpc_pkg::light_mode_t'(cfg_data[1:0]);
				ilgpc_pkg::REG_ON_THR:     on_thr_q     <= cfg_data;
				ilgpc_pkg::REG_OFF_THR:    off_thr_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign s_tready = q_ready;

	ilgpc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.gain        (s_tdata),
		.light_mode  (light_mode_q),
		.on_thr      (on_thr_q),
		.queue_ready (q_ready),
		.push        (push),
		.item        (push_item)
	);

	ilgpc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.ready     (q_ready),
		.pop       (pop),
		.avail     (avail),
		.head      (head)
	);

	ilgpc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.avail      (avail),
		.head       (head),
		.pop        (pop),
		.light_mode (light_mode_q),
		.on_thr     (on_thr_q),
		.off_thr    (off_thr_q),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.result     (result)
	);

	assign m_tdata = {1'b0, result.qualified, result.stop, result.start,
		result.written, result.duty_permille, result.running};

endmodule
